>>> sv/rsos_pkg.sv
// Shared types, constants and tangent table for the range sweep object segmenter.
package rsos_pkg;

    localparam int unsigned ANGLE_W = 8;
    localparam int unsigned RANGE_W = 10;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned WIDTH_W = 32;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE   = 8'd180;
    localparam logic [ANGLE_W-1:0] RIGHT_ANGLE = 8'd90;

    localparam logic [RANGE_W-1:0] IR_THRESHOLD_RESET = 10'd100;
    localparam logic [COUNT_W-1:0] MIN_RUN_RESET      = 8'd2;
    localparam logic [ANGLE_W-1:0] CENTER_TRIM_RESET  = 8'd13;
    localparam logic signed [WIDTH_W-1:0] BEST_WIDTH_RESET = 32'sd51200;
    localparam logic signed [WIDTH_W-1:0] WIDTH_MAX = 32'sh7FFF_FFFF;
    localparam logic [COUNT_W-1:0] RUN_RESTART = 8'd2;

    typedef enum logic [1:0] {
        REG_IR_THRESHOLD = 2'd0,
        REG_MIN_RUN      = 2'd1,
        REG_CENTER_TRIM  = 2'd2
    } reg_index_t;

    typedef logic [14:0] tan_entry_t;

    localparam tan_entry_t TAN_Q8_QUARTER [90] = '{
        15'd0,    15'd4,    15'd9,    15'd13,   15'd18,   15'd22,   15'd27,   15'd31,
        15'd36,   15'd41,   15'd45,   15'd50,   15'd54,   15'd59,   15'd64,   15'd69,
        15'd73,   15'd78,   15'd83,   15'd88,   15'd93,   15'd98,   15'd103,  15'd109,
        15'd114,  15'd119,  15'd125,  15'd130,  15'd136,  15'd142,  15'd148,  15'd154,
        15'd160,  15'd166,  15'd173,  15'd179,  15'd186,  15'd193,  15'd200,  15'd207,
        15'd215,  15'd223,  15'd231,  15'd239,  15'd247,  15'd256,  15'd265,  15'd275,
        15'd284,  15'd294,  15'd305,  15'd316,  15'd328,  15'd340,  15'd352,  15'd366,
        15'd380,  15'd394,  15'd410,  15'd426,  15'd443,  15'd462,  15'd481,  15'd502,
        15'd525,  15'd549,  15'd575,  15'd603,  15'd634,  15'd667,  15'd703,  15'd743,
        15'd788,  15'd837,  15'd893,  15'd955,  15'd1027, 15'd1109, 15'd1204, 15'd1317,
        15'd1452, 15'd1616, 15'd1822, 15'd2085, 15'd2436, 15'd2926, 15'd3661, 15'd4885,
        15'd7331, 15'd14666
    };

    function automatic logic signed [WIDTH_W-1:0] tan_q8(input logic [ANGLE_W-1:0] deg);
        logic [ANGLE_W-1:0] d;
        logic [ANGLE_W-1:0] mirror;
        logic signed [WIDTH_W-1:0] mag;
        d = (deg > MAX_ANGLE) ? deg - MAX_ANGLE : deg;
        mirror = MAX_ANGLE - d;
        if (d == MAX_ANGLE) begin
            tan_q8 = '0;
        end else if (d == RIGHT_ANGLE) begin
            tan_q8 = WIDTH_MAX;
        end else if (d > RIGHT_ANGLE) begin
            mag = $signed({17'd0, TAN_Q8_QUARTER[mirror[6:0]]});
            tan_q8 = -mag;
        end else begin
            tan_q8 = $signed({17'd0, TAN_Q8_QUARTER[d[6:0]]});
        end
    endfunction

    function automatic logic [ANGLE_W-1:0] sat_add8(input logic [ANGLE_W-1:0] a,
                                                    input logic [ANGLE_W-1:0] b);
        logic [ANGLE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add8 = s[ANGLE_W] ? '1 : s[ANGLE_W-1:0];
    endfunction

endpackage

>>> sv/rsos_width.sv
// Object width: tangent lookup times distance, halved toward zero, saturated to Q24.8.
module rsos_width (
    input  logic [rsos_pkg::COUNT_W-1:0]        run_length,
    input  logic [rsos_pkg::RANGE_W-1:0]        range_cm,
    output logic signed [rsos_pkg::WIDTH_W-1:0] width_q8
);
    import rsos_pkg::*;

    localparam int unsigned PROD_W = WIDTH_W + RANGE_W + 1;
    localparam logic signed [PROD_W-1:0] SAT_HI = 43'sd2147483647;
    localparam logic signed [PROD_W-1:0] SAT_LO = -43'sd2147483648;

    logic signed [WIDTH_W-1:0] tan_val;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_adj;
    logic signed [PROD_W-1:0]  half;

    assign tan_val  = tan_q8(run_length);
    assign prod     = PROD_W'(tan_val) * $signed({1'b0, range_cm});
    assign prod_adj = prod + $signed(PROD_W'(prod[PROD_W-1]));
    assign half     = prod_adj >>> 1;

    always_comb
    begin
        if (half > SAT_HI) begin
            width_q8 = WIDTH_MAX;
        end else if (half < SAT_LO) begin
            width_q8 = {1'b1, {(WIDTH_W-1){1'b0}}};
        end else begin
            width_q8 = half[WIDTH_W-1:0];
        end
    end

endmodule

>>> sv/range_sweep_object_segmenter.sv
// Top level of the range sweep object segmenter: APB registers, sample pipeline, object tracking.
//
//  channel  | direction | handshake                     | payload
//  sample   | in        | sample_valid / sample_ready   | scan_angle ir_range_cm sonar_range_cm sweep_last
//  result   | out       | result_valid / result_ready   | object_total smallest_number smallest_range_cm
//           |           |                               | smallest_width_q8 center_half_deg sweep_done
//  apb      | in        | psel penable pwrite / pready  | paddr pwdata prdata
//
//  One request per cycle while result_ready is high; samples pass the input, then the result register.
//  The tracking update (tangent lookup, one 32x11 multiply, compare) is combinational.
//  Reset sets registers to defaults and clears all tracking state; no clearing pass.
//  A stalled result holds the result register; one more sample waits in the input register.
module range_sweep_object_segmenter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  logic [rsos_pkg::ANGLE_W-1:0]        scan_angle,
    input  logic [rsos_pkg::RANGE_W-1:0]        ir_range_cm,
    input  logic [rsos_pkg::RANGE_W-1:0]        sonar_range_cm,
    input  logic                                sweep_last,
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [rsos_pkg::COUNT_W-1:0]        object_total,
    output logic [rsos_pkg::COUNT_W-1:0]        smallest_number,
    output logic [rsos_pkg::RANGE_W-1:0]        smallest_range_cm,
    output logic signed [rsos_pkg::WIDTH_W-1:0] smallest_width_q8,
    output logic signed [rsos_pkg::RANGE_W-1:0] center_half_deg,
    output logic                                sweep_done,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsos_pkg::ADDR_W-1:0]         paddr,
    input  logic [rsos_pkg::DATA_W-1:0]         pwdata,
    output logic [rsos_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);
    import rsos_pkg::*;

    logic [RANGE_W-1:0] ir_threshold_reg;
    logic [COUNT_W-1:0] min_run_reg;
    logic [ANGLE_W-1:0] center_trim_reg;
    reg_index_t         reg_sel;
    logic               cfg_write;

    logic               s1_valid_reg;
    logic [ANGLE_W-1:0] s1_angle_reg;
    logic [RANGE_W-1:0] s1_ir_reg;
    logic [RANGE_W-1:0] s1_sonar_reg;
    logic               s1_last_reg;

    logic               in_view_reg, in_view_next;
    logic [COUNT_W-1:0] object_count_reg, object_count_next;
    logic [COUNT_W-1:0] run_length_reg, run_length_next;
    logic [ANGLE_W-1:0] run_start_reg, run_start_next;
    logic [RANGE_W-1:0] run_min_reg, run_min_next;
    logic [ANGLE_W-1:0] best_start_reg, best_start_next;
    logic [ANGLE_W-1:0] best_end_reg, best_end_next;
    logic [RANGE_W-1:0] best_range_reg, best_range_next;
    logic [COUNT_W-1:0] best_index_reg, best_index_next;
    logic signed [WIDTH_W-1:0] best_width_reg, best_width_next;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_total_reg;
    logic [COUNT_W-1:0] out_number_reg;
    logic [RANGE_W-1:0] out_range_reg;
    logic signed [WIDTH_W-1:0] out_width_reg;
    logic [RANGE_W-1:0] out_center_reg;
    logic               out_last_reg;

    logic               out_advance;
    logic               s1_fire;
    logic               declare;
    logic               take_best;
    logic [COUNT_W-1:0] rl_decl;
    logic [ANGLE_W-1:0] start_decl;
    logic [RANGE_W-1:0] min_decl;
    logic [ANGLE_W-1:0] end_angle;
    logic signed [WIDTH_W-1:0] run_width;
    logic [RANGE_W-1:0] center_calc;

    // configuration port
    assign pready    = 1'b1;
    assign reg_sel   = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ir_threshold_reg <= IR_THRESHOLD_RESET;
            min_run_reg      <= MIN_RUN_RESET;
            center_trim_reg  <= CENTER_TRIM_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_IR_THRESHOLD: ir_threshold_reg <= pwdata[RANGE_W-1:0];
                REG_MIN_RUN:      min_run_reg      <= pwdata[COUNT_W-1:0];
                REG_CENTER_TRIM:  center_trim_reg  <= pwdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_IR_THRESHOLD: prdata = DATA_W'(ir_threshold_reg);
            REG_MIN_RUN:      prdata = DATA_W'(min_run_reg);
            REG_CENTER_TRIM:  prdata = DATA_W'(center_trim_reg);
            default:          prdata = '0;
        endcase
    end

    // pipeline control
    assign out_advance  = !out_valid_reg || result_ready;
    assign s1_fire      = s1_valid_reg && out_advance;
    assign sample_ready = !s1_valid_reg || out_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (sample_ready) begin
            s1_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid) begin
            s1_angle_reg <= scan_angle;
            s1_ir_reg    <= ir_range_cm;
            s1_sonar_reg <= sonar_range_cm;
            s1_last_reg  <= sweep_last;
        end
    end

    // object tracking
    assign declare    = !in_view_reg && (run_length_reg >= min_run_reg);
    assign rl_decl    = declare ? RUN_RESTART : run_length_reg;
    assign start_decl = declare ? sat_add8(s1_angle_reg, 8'd2) : run_start_reg;
    assign min_decl   = declare ? s1_sonar_reg : run_min_reg;
    assign end_angle  = sat_add8(s1_angle_reg, 8'd1);

    rsos_width u_width (
        .run_length (rl_decl),
        .range_cm   (min_decl),
        .width_q8   (run_width)
    );

    assign take_best = (run_width < best_width_reg) && (declare || in_view_reg)
                       && (start_decl != end_angle);

    always_comb
    begin
        object_count_next = declare ? sat_add8(object_count_reg, 8'd1) : object_count_reg;
        best_start_next   = best_start_reg;
        best_end_next     = best_end_reg;
        best_range_next   = best_range_reg;
        best_index_next   = best_index_reg;
        best_width_next   = best_width_reg;
        if (s1_ir_reg < ir_threshold_reg) begin
            in_view_next    = declare || in_view_reg;
            run_length_next = sat_add8(rl_decl, 8'd1);
            run_start_next  = start_decl;
            run_min_next    = (s1_sonar_reg < min_decl) ? s1_sonar_reg : min_decl;
        end else begin
            in_view_next    = 1'b0;
            run_length_next = '0;
            run_start_next  = '0;
            run_min_next    = min_decl;
            if (take_best) begin
                best_start_next = start_decl;
                best_end_next   = end_angle;
                best_range_next = min_decl;
                best_index_next = object_count_next;
                best_width_next = run_width;
            end
        end
    end

    assign center_calc = RANGE_W'({2'b00, best_start_next} + {2'b00, best_end_next}
                                  - {2'b00, center_trim_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_view_reg      <= 1'b0;
            object_count_reg <= '0;
            run_length_reg   <= '0;
            run_start_reg    <= '0;
            run_min_reg      <= '0;
            best_start_reg   <= '0;
            best_end_reg     <= '0;
            best_range_reg   <= '0;
            best_index_reg   <= '0;
            best_width_reg   <= BEST_WIDTH_RESET;
        end else if (s1_fire) begin
            if (s1_last_reg) begin
                in_view_reg      <= 1'b0;
                object_count_reg <= '0;
                run_length_reg   <= '0;
                run_start_reg    <= '0;
                run_min_reg      <= '0;
                best_start_reg   <= '0;
                best_end_reg     <= '0;
                best_range_reg   <= '0;
                best_index_reg   <= '0;
                best_width_reg   <= BEST_WIDTH_RESET;
            end else begin
                in_view_reg      <= in_view_next;
                object_count_reg <= object_count_next;
                run_length_reg   <= run_length_next;
                run_start_reg    <= run_start_next;
                run_min_reg      <= run_min_next;
                best_start_reg   <= best_start_next;
                best_end_reg     <= best_end_next;
                best_range_reg   <= best_range_next;
                best_index_reg   <= best_index_next;
                best_width_reg   <= best_width_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire) begin
            out_total_reg  <= object_count_next;
            out_number_reg <= best_index_next;
            out_range_reg  <= best_range_next;
            out_width_reg  <= best_width_next;
            out_center_reg <= center_calc;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign result_valid      = out_valid_reg;
    assign object_total      = out_total_reg;
    assign smallest_number   = out_number_reg;
    assign smallest_range_cm = out_range_reg;
    assign smallest_width_q8 = out_width_reg;
    assign center_half_deg   = $signed(out_center_reg);
    assign sweep_done        = out_last_reg;

    a_index_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> smallest_number <= object_total)
        else $error("smallest object index exceeds object total");

    a_view_has_object: assert property (@(posedge clk) disable iff (!rst_n)
        in_view_reg |-> object_count_reg != '0)
        else $error("object in view with no object declared");

    a_idle_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !in_view_reg |-> run_start_reg == '0)
        else $error("run start angle held with no object in view");

    a_sweep_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> (object_count_reg == '0 && best_width_reg == BEST_WIDTH_RESET))
        else $error("state not cleared after end of sweep");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> s1_valid_reg)
        else $error("accepted sample lost before tracking stage");

endmodule
